>>> hw/rtl/apwq_pkg.sv
// ----------------------------------------------------------------------------
// Audio port write queue package
// Shared command codes, register indexes, reset values, types and the byte
// merge function used by the queue datapath.
// ----------------------------------------------------------------------------
package apwq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [1:0] CMD_WRITE_PORT  = 2'd0;
	localparam logic [1:0] CMD_PUSH_FRAME  = 2'd1;
	localparam logic [1:0] CMD_POP         = 2'd2;
	localparam logic [1:0] CMD_RESET_QUEUE = 2'd3;

	localparam int         CFG_IDX_W           = 1;
	localparam logic [0:0] REG_DRAIN_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_BACKOFF_STEP    = 1'b1;

	localparam logic [7:0] DRAIN_THRESHOLD_RST = 8'd32;
	localparam logic [7:0] BACKOFF_STEP_RST    = 8'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  port_index;
		logic [7:0]  port_value;
		logic        uploading;
		logic [31:0] reload;
	} item_t;

	typedef struct packed {
		logic [7:0] drain_threshold;
		logic [7:0] backoff_step;
	} cfg_t;

	// Zero bytes of keep take the matching byte of fill.
	function automatic logic [31:0] merge_zero_bytes(input logic [31:0] keep,
		input logic [31:0] fill);
		logic [31:0] r;
		r = keep;
		for (int b = 0; b < 4; b++) begin
			if (keep[8*b +: 8] == 8'd0) begin
				r[8*b +: 8] = fill[8*b +: 8];
			end
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/apwq_store.sv
// ----------------------------------------------------------------------------
// Audio port write queue entry store
// One write port and one registered read port, with write-to-read bypass
// when both hit the same entry at the same edge.
// ----------------------------------------------------------------------------
module apwq_store #(
	parameter int QUEUE_DEPTH = 16,
	localparam int AW = $clog2(QUEUE_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [QUEUE_DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/apwq_core.sv
// ----------------------------------------------------------------------------
// Audio port write queue core
// Queue pointers, age counter, port latch and merge carry; executes the item
// held in the input register and registers its result.
// ----------------------------------------------------------------------------
module apwq_core #(
	parameter int QUEUE_DEPTH = 16,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      in_command,
	input  logic            valid_s1,
	input  apwq_pkg::item_t item_s1,
	input  apwq_pkg::cfg_t  cfg,
	output logic            mem_we,
	output logic [AW-1:0]   mem_waddr,
	output logic [31:0]     mem_wdata,
	output logic            mem_re,
	output logic [AW-1:0]   mem_raddr,
	input  logic [31:0]     mem_rdata,
	output logic            done,
	output logic [31:0]     out_word,
	output logic            pop_valid,
	output logic            frame_skipped,
	output logic [CW-1:0]   queue_count
);
	import apwq_pkg::*;

	localparam int            SW        = CW + 1;
	localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_POS  = AW'(QUEUE_DEPTH - 1);

	logic [AW-1:0] wpos_q, wpos_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    age_q, age_d;
	logic [31:0]   latch_q, latch_d;
	// Bytes still owed to the oldest entry's zero bytes by full-queue merges.
	logic [31:0]   carry_q, carry_d;

	logic [31:0]   res_word;
	logic          res_pop, res_skip, enq;
	logic [SW-1:0] oldest;

	always_comb begin
		wpos_d    = wpos_q;
		count_d   = count_q;
		age_d     = age_q;
		latch_d   = latch_q;
		carry_d   = carry_q;
		mem_we    = 1'b0;
		mem_waddr = wpos_q;
		mem_wdata = latch_q;
		res_word  = 32'd0;
		res_pop   = 1'b0;
		res_skip  = 1'b0;
		enq       = 1'b0;
		if (valid_s1) begin
			case (item_s1.command)
				CMD_WRITE_PORT: begin
					if (!item_s1.uploading) begin
						latch_d[{item_s1.port_index, 3'b000} +: 8] = item_s1.port_value;
					end
				end
				CMD_PUSH_FRAME: begin
					if (item_s1.uploading) begin
						count_d = '0;
						carry_d = 32'd0;
					end else if (count_q == '0) begin
						age_d = 8'd0;
						enq   = 1'b1;
					end else if ((age_q >= cfg.drain_threshold) && (latch_q == 32'd0)) begin
						age_d    = age_q - cfg.backoff_step;
						res_skip = 1'b1;
					end else begin
						age_d = age_q + 8'd1;
						enq   = 1'b1;
					end
					if (enq) begin
						mem_we = 1'b1;
						wpos_d = (wpos_q == LAST_POS) ? '0 : wpos_q + AW'(1);
						if (count_q == DEPTH_CNT) begin
							// The overwritten oldest entry folds into the new oldest one.
							carry_d = merge_zero_bytes(mem_rdata, carry_q);
						end else begin
							count_d = count_q + CW'(1);
							if (count_q == '0) begin
								carry_d = 32'd0;
							end
						end
					end
				end
				CMD_POP: begin
					if (count_q != '0) begin
						count_d  = count_q - CW'(1);
						res_word = merge_zero_bytes(mem_rdata, carry_q);
						res_pop  = 1'b1;
						carry_d  = 32'd0;
					end
				end
				CMD_RESET_QUEUE: begin
					wpos_d  = '0;
					age_d   = 8'd0;
					count_d = '0;
					latch_d = item_s1.reload;
					carry_d = 32'd0;
				end
				default: begin
				end
			endcase
		end
	end

	// The next item's read address follows the state this item leaves.
	always_comb begin
		oldest = SW'(wpos_d) - SW'(count_d);
		if (oldest[SW-1]) begin
			oldest = oldest + SW'(QUEUE_DEPTH);
		end
		mem_re    = accept;
		mem_raddr = (in_command == CMD_POP) ? oldest[AW-1:0] : wpos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q        <= '0;
			count_q       <= '0;
			age_q         <= 8'd0;
			latch_q       <= 32'd0;
			carry_q       <= 32'd0;
			done          <= 1'b0;
			out_word      <= 32'd0;
			pop_valid     <= 1'b0;
			frame_skipped <= 1'b0;
			queue_count   <= '0;
		end else begin
			wpos_q  <= wpos_d;
			count_q <= count_d;
			age_q   <= age_d;
			latch_q <= latch_d;
			carry_q <= carry_d;
			done    <= valid_s1;
			if (valid_s1) begin
				out_word      <= res_word;
				pop_valid     <= res_pop;
				frame_skipped <= res_skip;
				queue_count   <= count_d;
			end
		end
	end

endmodule

>>> hw/rtl/audio_port_write_queue.sv
// ----------------------------------------------------------------------------
// Audio port write queue
// Frame queue of four-byte audio port snapshots with full-queue byte merge.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is taken at a rising edge where start is high and
// busy is low; busy stays low, so one command can enter every cycle. The
// command and its operands are registered, executed in the next cycle
// against the queue state, and the result is shown on the result ports for
// one cycle with done high. Every command produces exactly one result.
// Throughput is one command per cycle, set by the entry store, which has
// separate write and read ports and whose registered read is issued at
// acceptance time.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes the drain threshold (index 0) or the backoff step
// (index 1); write it only while no command is in flight.
// Reset empties the queue, clears the latch and age counter and restores the
// register defaults; the entry store is not cleared. The receiver cannot
// stall, so results are never held back.
// ----------------------------------------------------------------------------
module audio_port_write_queue #(
	parameter int QUEUE_DEPTH = apwq_pkg::QUEUE_DEPTH_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic [1:0]                    port_index,
	input  logic [7:0]                    port_value,
	input  logic                          uploading,
	input  logic [7:0]                    reload_byte0,
	input  logic [7:0]                    reload_byte1,
	input  logic [7:0]                    reload_byte2,
	input  logic [7:0]                    reload_byte3,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [apwq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output logic                          done,
	output logic [7:0]                    out_byte0,
	output logic [7:0]                    out_byte1,
	output logic [7:0]                    out_byte2,
	output logic [7:0]                    out_byte3,
	output logic                          pop_valid,
	output logic                          frame_skipped,
	output logic [CW-1:0]                 queue_count
);
	import apwq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic          accept;
	logic          valid_s1;
	item_t         item_s1;
	cfg_t          cfg_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;
	logic [31:0]   out_word;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drain_threshold <= DRAIN_THRESHOLD_RST;
			cfg_q.backoff_step    <= BACKOFF_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DRAIN_THRESHOLD: cfg_q.drain_threshold <= cfg_data;
				REG_BACKOFF_STEP:    cfg_q.backoff_step    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command    <= command;
			item_s1.port_index <= port_index;
			item_s1.port_value <= port_value;
			item_s1.uploading  <= uploading;
			item_s1.reload     <= {reload_byte3, reload_byte2, reload_byte1, reload_byte0};
		end
	end

	apwq_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	apwq_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_command    (command),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.cfg           (cfg_q),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.done          (done),
		.out_word      (out_word),
		.pop_valid     (pop_valid),
		.frame_skipped (frame_skipped),
		.queue_count   (queue_count)
	);

	assign out_byte0 = out_word[7:0];
	assign out_byte1 = out_word[15:8];
	assign out_byte2 = out_word[23:16];
	assign out_byte3 = out_word[31:24];

endmodule

>>> hw/rtl/apwq_checker.sv
// ----------------------------------------------------------------------------
// Audio port write queue checker
// Port-level assertions on result timing and result consistency.
// ----------------------------------------------------------------------------
module apwq_checker #(
	parameter int QUEUE_DEPTH = 16,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input logic [7:0]    out_byte0,
	input logic [7:0]    out_byte1,
	input logic [7:0]    out_byte2,
	input logic [7:0]    out_byte3,
	input logic          pop_valid,
	input logic          frame_skipped,
	input logic [CW-1:0] queue_count
);

	// A result only follows a taken transaction, via valid_s1 then done.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching command transaction");

	a_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !pop_valid) |->
		(out_byte0 == 8'd0 && out_byte1 == 8'd0 && out_byte2 == 8'd0 && out_byte3 == 8'd0))
		else $error("output bytes nonzero without a pop");

	a_pop_not_skip: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(pop_valid && frame_skipped))
		else $error("pop and frame skip in the same result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (queue_count <= CW'(QUEUE_DEPTH)))
		else $error("queue count above depth");

endmodule

bind audio_port_write_queue apwq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_apwq_checker (.*);

>>> sim/tb_audio_port_write_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio port write queue testbench
// Drives command transactions (port writes, frame pushes, pops, queue resets)
// with random idle cycles, keeps a cycle-free model of the latch, the
// circular entry store and the age counter, and compares every result
// strobe byte by byte against it or a typed row. A directed table comes
// first, then random phases with varied drain thresholds and backoff steps.
// ----------------------------------------------------------------------------
module tb_audio_port_write_queue;
	import apwq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic [31:0] data;
		logic        popped;
		logic        skipped;
		logic [4:0]  count;
	} frame_result_t;

	typedef struct {
		item_t         it;
		int            reps;
		bit            typed;
		frame_result_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           command;
	logic [1:0]           port_index;
	logic [7:0]           port_value;
	logic                 uploading;
	logic [7:0]           reload_byte0;
	logic [7:0]           reload_byte1;
	logic [7:0]           reload_byte2;
	logic [7:0]           reload_byte3;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 done;
	logic [7:0]           out_byte0;
	logic [7:0]           out_byte1;
	logic [7:0]           out_byte2;
	logic [7:0]           out_byte3;
	logic                 pop_valid;
	logic                 frame_skipped;
	logic [4:0]           queue_count;

	// Expectation typed into the directed table travels with the transaction.
	bit            drv_typed;
	frame_result_t drv_want;
	bit            idle_en;

	// Model state
	logic [31:0] slots [DEPTH];
	logic [3:0]  wr_pos;
	logic [4:0]  fill_cnt;
	logic [7:0]  age;
	logic [31:0] latch;
	logic [7:0]  drain_thr;
	logic [7:0]  backoff;

	frame_result_t pending_results[$];
	dir_row_t      dir_rows[$];

	int errors;
	int items_sent;
	int results_checked;
	int pops_delivered;
	int skips_seen;
	int merges_seen;
	int upload_clears;

	audio_port_write_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.port_index(port_index),
		.port_value(port_value),
		.uploading(uploading),
		.reload_byte0(reload_byte0),
		.reload_byte1(reload_byte1),
		.reload_byte2(reload_byte2),
		.reload_byte3(reload_byte3),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.out_byte0(out_byte0),
		.out_byte1(out_byte1),
		.out_byte2(out_byte2),
		.out_byte3(out_byte3),
		.pop_valid(pop_valid),
		.frame_skipped(frame_skipped),
		.queue_count(queue_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
	endtask

	task automatic compute_frame_result(input item_t it, output frame_result_t r);
		logic [3:0] slot;
		logic [3:0] nxt;
		logic [3:0] head;
		bit skip;
		r = '0;
		skip = 1'b0;
		case (it.command)
			CMD_WRITE_PORT: begin
				if (!it.uploading) begin
					latch[8*it.port_index +: 8] = it.port_value;
				end
			end
			CMD_PUSH_FRAME: begin
				if (it.uploading) begin
					fill_cnt = '0;
					upload_clears++;
				end else begin
					if (fill_cnt == 0) begin
						age = '0;
					end else if (age >= drain_thr && latch == 32'd0) begin
						age = age - backoff;
						r.skipped = 1'b1;
						skip = 1'b1;
						skips_seen++;
					end else begin
						age = age + 8'd1;
					end
					if (!skip) begin
						slot = wr_pos;
						nxt = slot + 4'd1;
						wr_pos = nxt;
						if (fill_cnt >= DEPTH) begin
							// Full: the oldest entry fills the zero bytes of the one after it.
							fill_cnt = 5'(DEPTH);
							for (int b = 0; b < 4; b++) begin
								if (slots[nxt][8*b +: 8] == 8'd0) begin
									slots[nxt][8*b +: 8] = slots[slot][8*b +: 8];
								end
							end
							merges_seen++;
						end else begin
							fill_cnt = fill_cnt + 5'd1;
						end
						slots[slot] = latch;
					end
				end
			end
			CMD_POP: begin
				if (fill_cnt != 0) begin
					head = wr_pos - fill_cnt[3:0];
					fill_cnt = fill_cnt - 5'd1;
					r.data = slots[head];
					r.popped = 1'b1;
					pops_delivered++;
				end
			end
			default: begin
				wr_pos = '0;
				age = '0;
				fill_cnt = '0;
				latch = it.reload;
			end
		endcase
		r.count = fill_cnt;
	endtask

	always @(posedge clk) begin : monitor
		frame_result_t got;
		frame_result_t want;
		frame_result_t pred;
		item_t it;
		if (arst_n) begin
			if (done === 1'b1) begin
				got = {out_byte3, out_byte2, out_byte1, out_byte0, pop_valid, frame_skipped,
					queue_count};
				if (pending_results.size() == 0) begin
					report_mismatch("result strobe with no transaction outstanding");
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					for (int b = 0; b < 4; b++) begin
						if (got.data[8*b +: 8] !== want.data[8*b +: 8]) begin
							report_mismatch($sformatf("out_byte%0d got %h expected %h", b,
								got.data[8*b +: 8], want.data[8*b +: 8]));
						end
					end
					if (got.popped !== want.popped) begin
						report_mismatch($sformatf("pop_valid got %b expected %b",
							got.popped, want.popped));
					end
					if (got.skipped !== want.skipped) begin
						report_mismatch($sformatf("frame_skipped got %b expected %b",
							got.skipped, want.skipped));
					end
					if (got.count !== want.count) begin
						report_mismatch($sformatf("queue_count got %0d expected %0d",
							got.count, want.count));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DRAIN_THRESHOLD) begin
					drain_thr = cfg_data;
				end else begin
					backoff = cfg_data;
				end
			end
			if (start && !busy) begin
				it.command = command;
				it.port_index = port_index;
				it.port_value = port_value;
				it.uploading = uploading;
				it.reload = {reload_byte3, reload_byte2, reload_byte1, reload_byte0};
				compute_frame_result(it, pred);
				pending_results.push_back(drv_typed ? drv_want : pred);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input item_t it, input bit typed, input frame_result_t want);
		while (idle_en && $urandom_range(99) < 29) begin
			start = 1'b0;
			@(negedge clk);
		end
		command = it.command;
		port_index = it.port_index;
		port_value = it.port_value;
		uploading = it.uploading;
		{reload_byte3, reload_byte2, reload_byte1, reload_byte0} = it.reload;
		drv_typed = typed;
		drv_want = want;
		start = 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		start = 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic frame_result_t mk_res(input logic [31:0] data, input logic popped,
		input logic skipped, input logic [4:0] count);
		frame_result_t r;
		r.data = data;
		r.popped = popped;
		r.skipped = skipped;
		r.count = count;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input logic [1:0] cmd, input logic [1:0] idx,
		input logic [7:0] val, input logic upl, input logic [31:0] reload, input int reps,
		input bit typed, input frame_result_t want);
		dir_row_t d;
		d.it.command = cmd;
		d.it.port_index = idx;
		d.it.port_value = val;
		d.it.uploading = upl;
		d.it.reload = reload;
		d.reps = reps;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	function automatic item_t rand_item(input int push_pct, input int pop_pct,
		input int zero_pct);
		item_t it;
		int sel;
		sel = $urandom_range(99);
		if (sel < push_pct) begin
			it.command = CMD_PUSH_FRAME;
		end else if (sel < push_pct + pop_pct) begin
			it.command = CMD_POP;
		end else if (sel < 97) begin
			it.command = CMD_WRITE_PORT;
		end else begin
			it.command = CMD_RESET_QUEUE;
		end
		it.port_index = 2'($urandom_range(3));
		it.port_value = ($urandom_range(99) < zero_pct) ? 8'd0 : 8'($urandom_range(255));
		it.uploading = ($urandom_range(99) < 5);
		it.reload = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
		return it;
	endfunction

	initial begin
		#1_000_000;
		$display("audio_port_write_queue verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] thr_set [N_PHASES];
		logic [7:0] step_set [N_PHASES];
		int push_pct;
		int pop_pct;
		int guard;

		errors = 0;
		items_sent = 0;
		results_checked = 0;
		pops_delivered = 0;
		skips_seen = 0;
		merges_seen = 0;
		upload_clears = 0;
		idle_en = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			slots[i] = '0;
		end
		wr_pos = '0;
		fill_cnt = '0;
		age = '0;
		latch = '0;
		drain_thr = DRAIN_THRESHOLD_RST;
		backoff = BACKOFF_STEP_RST;

		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_WRITE_PORT;
		port_index = '0;
		port_value = '0;
		uploading = 1'b0;
		reload_byte0 = '0;
		reload_byte1 = '0;
		reload_byte2 = '0;
		reload_byte3 = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DRAIN_THRESHOLD;
		cfg_data = '0;
		drv_typed = 1'b0;
		drv_want = '0;

		// Directed table, run with the reset register values.
		dir_rows.push_back(mk_row(CMD_POP, 0, 8'h00, 0, 0, 1, 1, mk_res(0, 0, 0, 0)));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 1, 1, mk_res(0, 0, 0, 1)));
		dir_rows.push_back(mk_row(CMD_WRITE_PORT, 0, 8'hFF, 0, 0, 1, 1, mk_res(0, 0, 0, 1)));
		dir_rows.push_back(mk_row(CMD_WRITE_PORT, 3, 8'h80, 0, 0, 1, 1, mk_res(0, 0, 0, 1)));
		dir_rows.push_back(mk_row(CMD_WRITE_PORT, 1, 8'h01, 1, 0, 1, 1, mk_res(0, 0, 0, 1)));
		dir_rows.push_back(mk_row(CMD_WRITE_PORT, 2, 8'h00, 0, 0, 1, 1, mk_res(0, 0, 0, 1)));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 1, 1, mk_res(0, 0, 0, 2)));
		dir_rows.push_back(mk_row(CMD_POP, 0, 8'h00, 0, 0, 1, 1, mk_res(0, 1, 0, 1)));
		dir_rows.push_back(mk_row(CMD_POP, 0, 8'h00, 0, 0, 1, 1,
			mk_res(32'h8000_00FF, 1, 0, 0)));
		dir_rows.push_back(mk_row(CMD_RESET_QUEUE, 0, 8'h00, 0, 32'h4433_2211, 1, 1,
			mk_res(0, 0, 0, 0)));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 1, 0, 1, 1, mk_res(0, 0, 0, 0)));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 1, 1, mk_res(0, 0, 0, 1)));
		dir_rows.push_back(mk_row(CMD_WRITE_PORT, 1, 8'h00, 0, 0, 1, 0, '0));
		// Overflow: the last pushes merge the oldest entry into its successor.
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 17, 0, '0));
		dir_rows.push_back(mk_row(CMD_POP, 0, 8'h00, 0, 0, 17, 0, '0));
		dir_rows.push_back(mk_row(CMD_RESET_QUEUE, 0, 8'h00, 0, 32'hFFFF_FFFF, 1, 1,
			mk_res(0, 0, 0, 0)));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 3, 0, '0));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 1, 0, 1, 1, mk_res(0, 0, 0, 0)));
		dir_rows.push_back(mk_row(CMD_RESET_QUEUE, 0, 8'h00, 0, 0, 1, 1, mk_res(0, 0, 0, 0)));
		// Zero latch: the age counter reaches the threshold and frames get skipped.
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 34, 0, '0));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 6, 0, '0));
		dir_rows.push_back(mk_row(CMD_WRITE_PORT, 2, 8'h5A, 0, 0, 1, 0, '0));
		dir_rows.push_back(mk_row(CMD_PUSH_FRAME, 0, 8'h00, 0, 0, 1, 0, '0));
		dir_rows.push_back(mk_row(CMD_POP, 0, 8'h00, 0, 0, 3, 0, '0));

		thr_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd2, 8'd32};
		step_set = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd0, 8'd200, 8'd4};
		thr_set[5] = 8'($urandom_range(255));
		step_set[5] = 8'($urandom_range(255));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			repeat (dir_rows[r].reps) begin
				send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(REG_DRAIN_THRESHOLD, thr_set[p]);
			write_reg(REG_BACKOFF_STEP, step_set[p]);
			// One phase runs back to back with no idle cycles at all.
			idle_en = (p != 3);
			push_pct = $urandom_range(25, 60);
			pop_pct = $urandom_range(10, 30);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(rand_item(push_pct, pop_pct, 40), 1'b0, '0);
			end
		end
		start = 1'b0;

		guard = 0;
		while (pending_results.size() != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		end

		$display("Sent %0d commands, checked %0d results with %0d errors.",
			items_sent, results_checked, errors);
		$display("Seen %0d pops, %0d skipped frames, %0d full-queue merges, %0d upload clears.",
			pops_delivered, skips_seen, merges_seen, upload_clears);
		if (errors == 0) begin
			$display("audio_port_write_queue verification clean");
		end else begin
			$display("audio_port_write_queue verification failed");
		end
		$finish;
	end

endmodule
